FILE: rtl/urtb_pkg.sv
// Shared types and constants for the serial port ring buffer block.
package urtb_pkg;

	localparam int RX_DEPTH_DEF = 512;
	localparam int TX_DEPTH_DEF = 256;
	localparam int RX_FILL_W    = 10;
	localparam int TX_FILL_W    = 9;

	typedef enum logic [1:0] {
		ACT_HOST_SEND = 2'd0,
		ACT_HOST_GET  = 2'd1,
		ACT_LINE_RX   = 2'd2,
		ACT_TX_READY  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic load;
	} ctrl_cmd_t;

endpackage

FILE: rtl/urtb_ctrl.sv
// Controller state machine: input handshake, sequencing and output valid.
module urtb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output urtb_pkg::ctrl_cmd_t cmd
);

	urtb_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             can_load;

	assign in_ready  = (state_q == urtb_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.load  = 1'b0;
		unique case (state_q)
			urtb_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = urtb_pkg::S_EXEC;
				end
			end
			urtb_pkg::S_EXEC: begin
				// The result waits here until the output register is free.
				if (can_load) begin
					cmd.load = 1'b1;
					state_d  = urtb_pkg::S_IDLE;
				end
			end
			default: state_d = urtb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= urtb_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/urtb_dp.sv
// Datapath: both ring buffers, their pointers and counts, the enable flag and the result register.
module urtb_dp #(
	parameter int RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  urtb_pkg::ctrl_cmd_t            cmd,
	input  logic [1:0]                     action,
	input  logic [7:0]                     data_byte,
	output logic                           accepted,
	output logic [7:0]                     read_byte,
	output logic                           line_valid,
	output logic [7:0]                     line_byte,
	output logic                           tx_enable_out,
	output logic                           rx_available,
	output logic                           tx_full,
	output logic [urtb_pkg::RX_FILL_W-1:0] rx_fill,
	output logic [urtb_pkg::TX_FILL_W-1:0] tx_fill
);

	localparam int RXP = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TXP = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int RXC = $clog2(RX_DEPTH + 1);
	localparam int TXC = $clog2(TX_DEPTH + 1);
	localparam logic [RXP-1:0] RX_LAST = RXP'(RX_DEPTH - 1);
	localparam logic [TXP-1:0] TX_LAST = TXP'(TX_DEPTH - 1);
	localparam logic [RXC-1:0] RX_FULL = RXC'(RX_DEPTH);
	localparam logic [TXC-1:0] TX_FULL = TXC'(TX_DEPTH);

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];

	logic [RXP-1:0] rx_head_q, rx_tail_q;
	logic [TXP-1:0] tx_head_q, tx_tail_q;
	logic [RXC-1:0] rx_count_q;
	logic [TXC-1:0] tx_count_q;
	logic           tx_irq_q;

	logic [7:0] rx_rdata_q, tx_rdata_q;
	logic       acc_q, get_q, line_q;

	urtb_pkg::action_t act;
	logic rx_push, rx_pop, tx_push, tx_pop, irq_set, irq_clr;

	logic [RXC+urtb_pkg::RX_FILL_W-1:0] rx_fill_ext;
	logic [TXC+urtb_pkg::TX_FILL_W-1:0] tx_fill_ext;

	assign act = urtb_pkg::action_t'(action);

	always_comb begin
		rx_push = 1'b0;
		rx_pop  = 1'b0;
		tx_push = 1'b0;
		tx_pop  = 1'b0;
		irq_set = 1'b0;
		irq_clr = 1'b0;
		if (cmd.start) begin
			unique case (act)
				urtb_pkg::ACT_HOST_SEND: begin
					tx_push = (tx_count_q != TX_FULL);
					irq_set = tx_push;
				end
				urtb_pkg::ACT_HOST_GET: rx_pop  = (rx_count_q != '0);
				urtb_pkg::ACT_LINE_RX:  rx_push = (rx_count_q != RX_FULL);
				urtb_pkg::ACT_TX_READY: begin
					if (tx_irq_q) begin
						tx_pop = (tx_count_q != '0);
						// The flag drops once the queue is empty after this event.
						irq_clr = (tx_count_q == '0) || (tx_count_q == TXC'(1));
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			rx_count_q <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			tx_count_q <= '0;
			tx_irq_q   <= 1'b0;
		end else begin
			if (rx_push) begin
				rx_head_q  <= (rx_head_q == RX_LAST) ? '0 : rx_head_q + RXP'(1);
				rx_count_q <= rx_count_q + RXC'(1);
			end
			if (rx_pop) begin
				rx_tail_q  <= (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + RXP'(1);
				rx_count_q <= rx_count_q - RXC'(1);
			end
			if (tx_push) begin
				tx_head_q  <= (tx_head_q == TX_LAST) ? '0 : tx_head_q + TXP'(1);
				tx_count_q <= tx_count_q + TXC'(1);
			end
			if (tx_pop) begin
				tx_tail_q  <= (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + TXP'(1);
				tx_count_q <= tx_count_q - TXC'(1);
			end
			if (irq_set) begin
				tx_irq_q <= 1'b1;
			end else if (irq_clr) begin
				tx_irq_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_push) begin
			rx_mem[rx_head_q] <= data_byte;
		end
		if (rx_pop) begin
			rx_rdata_q <= rx_mem[rx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_push) begin
			tx_mem[tx_head_q] <= data_byte;
		end
		if (tx_pop) begin
			tx_rdata_q <= tx_mem[tx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q  <= rx_push || rx_pop || tx_push || tx_pop;
			get_q  <= rx_pop;
			line_q <= tx_pop;
		end
	end

	assign rx_fill_ext = {{urtb_pkg::RX_FILL_W{1'b0}}, rx_count_q};
	assign tx_fill_ext = {{urtb_pkg::TX_FILL_W{1'b0}}, tx_count_q};

	// Counts already hold their post-event values when the result is loaded.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			accepted      <= acc_q;
			read_byte     <= get_q ? rx_rdata_q : 8'd0;
			line_valid    <= line_q;
			line_byte     <= line_q ? tx_rdata_q : 8'd0;
			tx_enable_out <= tx_irq_q;
			rx_available  <= (rx_count_q != '0);
			tx_full       <= (tx_count_q == TX_FULL);
			rx_fill       <= rx_fill_ext[urtb_pkg::RX_FILL_W-1:0];
			tx_fill       <= tx_fill_ext[urtb_pkg::TX_FILL_W-1:0];
		end
	end

endmodule

FILE: rtl/uart_rx_tx_ring_buffers.sv
// Top level of the serial port receive and transmit ring buffer block.
// Usage:
// One input channel (in_valid/in_ready, action, data_byte) carries events: host
// send, host get, received line byte and transmitter ready. Each transaction
// produces exactly one result transaction on the output channel
// (out_valid/out_ready) with the pop data, the line byte and the queue status.
// Sequence: the accepting edge updates pointers, counts and the memory and
// registers the read data; the result register is then loaded once it is
// free, which raises out_valid. The block takes no new event before it is
// through with the last, since in_ready is low from acceptance until the
// cycle that loads the result register.
// Reset empties both queues and clears the transmit enable flag at once; the
// buffer memories are not cleared and need no clearing pass.
// When the receiver stalls, the result is held in the output register, one
// further event is accepted and processed, and in_ready then stays low until
// the held result is taken.
module uart_rx_tx_ring_buffers #(
	parameter int RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [7:0]                     data_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic [7:0]                     read_byte,
	output logic                           line_valid,
	output logic [7:0]                     line_byte,
	output logic                           tx_enable_out,
	output logic                           rx_available,
	output logic                           tx_full,
	output logic [urtb_pkg::RX_FILL_W-1:0] rx_fill,
	output logic [urtb_pkg::TX_FILL_W-1:0] tx_fill
);

	urtb_pkg::ctrl_cmd_t cmd;

	urtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	urtb_dp #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.data_byte     (data_byte),
		.accepted      (accepted),
		.read_byte     (read_byte),
		.line_valid    (line_valid),
		.line_byte     (line_byte),
		.tx_enable_out (tx_enable_out),
		.rx_available  (rx_available),
		.tx_full       (tx_full),
		.rx_fill       (rx_fill),
		.tx_fill       (tx_fill)
	);

	// A non-empty transmit queue always has its enable flag set.
	a_tx_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tx_fill != '0) |-> tx_enable_out)
		else $error("transmit queue holds data with the enable flag clear");

	a_line_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_valid |-> accepted)
		else $error("line byte handed out without an accepted pop");

	// One event is in flight at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second event accepted while one is in progress");

endmodule

FILE: sim/ring_buffer_checker.sv
// Checker for the serial port ring buffers: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module ring_buffer_checker
	import urtb_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [7:0]           data_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 accepted,
	input  logic [7:0]           read_byte,
	input  logic                 line_valid,
	input  logic [7:0]           line_byte,
	input  logic                 tx_enable_out,
	input  logic                 rx_available,
	input  logic                 tx_full,
	input  logic [RX_FILL_W-1:0] rx_fill,
	input  logic [TX_FILL_W-1:0] tx_fill,
	output int                   fail_count,
	output int                   result_pending
);

	typedef struct packed {
		logic                 accepted;
		logic [7:0]           read_byte;
		logic                 line_valid;
		logic [7:0]           line_byte;
		logic                 tx_enable;
		logic                 rx_avail;
		logic                 tx_full;
		logic [RX_FILL_W-1:0] rx_fill;
		logic [TX_FILL_W-1:0] tx_fill;
	} port_status_t;

	logic [7:0]   rx_mem [RX_DEPTH];
	logic [7:0]   tx_mem [TX_DEPTH];
	int           rx_wr, rx_rd, rx_count;
	int           tx_wr, tx_rd, tx_count;
	logic         tx_irq_on;
	port_status_t status_q [$];

	function automatic int wrap_next(input int pos, input int depth);
		return (pos + 1 >= depth) ? 0 : pos + 1;
	endfunction

	function automatic port_status_t predict_event(input action_t act, input logic [7:0] b);
		port_status_t r;
		r = '0;
		case (act)
			ACT_HOST_SEND: begin
				if (tx_count < TX_DEPTH) begin
					tx_mem[tx_wr] = b;
					tx_wr = wrap_next(tx_wr, TX_DEPTH);
					tx_count++;
					tx_irq_on = 1'b1;
					r.accepted = 1'b1;
				end
			end
			ACT_HOST_GET: begin
				if (rx_count != 0) begin
					r.read_byte = rx_mem[rx_rd];
					rx_rd = wrap_next(rx_rd, RX_DEPTH);
					rx_count--;
					r.accepted = 1'b1;
				end
			end
			ACT_LINE_RX: begin
				if (rx_count < RX_DEPTH) begin
					rx_mem[rx_wr] = b;
					rx_wr = wrap_next(rx_wr, RX_DEPTH);
					rx_count++;
					r.accepted = 1'b1;
				end
			end
			ACT_TX_READY: begin
				// The line is only fed while the transmit interrupt is enabled.
				if (tx_irq_on) begin
					if (tx_count != 0) begin
						r.line_byte = tx_mem[tx_rd];
						tx_rd = wrap_next(tx_rd, TX_DEPTH);
						tx_count--;
						r.accepted = 1'b1;
						r.line_valid = 1'b1;
					end
					if (tx_count == 0)
						tx_irq_on = 1'b0;
				end
			end
			default: ;
		endcase
		r.tx_enable = tx_irq_on;
		r.rx_avail = (rx_count != 0);
		r.tx_full = (tx_count >= TX_DEPTH);
		r.rx_fill = rx_count[RX_FILL_W-1:0];
		r.tx_fill = tx_count[TX_FILL_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string field, input logic [9:0] want, input logic [9:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		result_pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		port_status_t want;
		if (!arst_n) begin
			rx_wr = 0;
			rx_rd = 0;
			rx_count = 0;
			tx_wr = 0;
			tx_rd = 0;
			tx_count = 0;
			tx_irq_on = 1'b0;
			status_q.delete();
		end else begin
			// The result leaving now belongs to an earlier transaction, so compare first.
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					$display("%0t ns: result with none expected, got accepted %0d read_byte %0d",
						$time, accepted, read_byte);
					fail_count++;
				end else begin
					want = status_q.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("read_byte", want.read_byte, read_byte);
					check_field("line_valid", want.line_valid, line_valid);
					check_field("line_byte", want.line_byte, line_byte);
					check_field("tx_enable_out", want.tx_enable, tx_enable_out);
					check_field("rx_available", want.rx_avail, rx_available);
					check_field("tx_full", want.tx_full, tx_full);
					check_field("rx_fill", want.rx_fill, rx_fill);
					check_field("tx_fill", want.tx_fill, tx_fill);
				end
			end
			if (in_valid && in_ready)
				status_q.push_back(predict_event(action_t'(action), data_byte));
		end
		result_pending = status_q.size();
	end

endmodule

FILE: sim/tb_top.sv
// Top of the testbench: clock, reset, stimulus, handshake idling and the verdict.
`timescale 1ns / 100ps

module tb_top;
	import urtb_pkg::*;

	localparam int RX_DEPTH       = RX_DEPTH_DEF;
	localparam int TX_DEPTH       = TX_DEPTH_DEF;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           action;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic                 accepted;
	logic [7:0]           read_byte;
	logic                 line_valid;
	logic [7:0]           line_byte;
	logic                 tx_enable_out;
	logic                 rx_available;
	logic                 tx_full;
	logic [RX_FILL_W-1:0] rx_fill;
	logic [TX_FILL_W-1:0] tx_fill;
	int                   fail_count;
	int                   result_pending;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_request  = 1'b0;
	logic hold_done     = 1'b0;

	uart_rx_tx_ring_buffers #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) dut (.*);

	ring_buffer_checker #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_checker (.*);

	always #1 clk = ~clk;

	function automatic action_t pick_action(input int w_send, input int w_get,
			input int w_line, input int w_ready);
		int roll;
		roll = $urandom_range(w_send + w_get + w_line + w_ready - 1);
		if (roll < w_send)
			return ACT_HOST_SEND;
		if (roll < w_send + w_get)
			return ACT_HOST_GET;
		if (roll < w_send + w_get + w_line)
			return ACT_LINE_RX;
		return ACT_TX_READY;
	endfunction

	// Called and left at a falling edge; valid stays high between back-to-back transactions.
	task automatic send_event(input action_t act, input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic run_mix(input int count, input int w_send, input int w_get,
			input int w_line, input int w_ready);
		repeat (count)
			send_event(pick_action(w_send, w_get, w_line, w_ready), 8'($urandom_range(255)));
	endtask

	initial begin : receiver
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// One long hold-off so that the block fills up and stalls its input.
			if (hold_request && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_HOST_SEND;
		data_byte = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 46;

		// Empty queues, a disabled transmitter and the byte extremes.
		send_event(ACT_HOST_GET, 8'hFF);
		send_event(ACT_TX_READY, 8'hFF);
		send_event(ACT_LINE_RX, 8'h00);
		send_event(ACT_LINE_RX, 8'hFF);
		send_event(ACT_LINE_RX, 8'h5A);
		send_event(ACT_HOST_GET, 8'h00);
		send_event(ACT_HOST_GET, 8'hFF);
		send_event(ACT_HOST_GET, 8'h00);
		send_event(ACT_HOST_GET, 8'hA5);
		send_event(ACT_HOST_SEND, 8'hFF);
		send_event(ACT_HOST_SEND, 8'h00);
		send_event(ACT_HOST_SEND, 8'hC3);
		send_event(ACT_TX_READY, 8'h00);
		send_event(ACT_TX_READY, 8'hFF);
		send_event(ACT_TX_READY, 8'h00);
		send_event(ACT_TX_READY, 8'h3C);
		send_event(ACT_HOST_SEND, 8'h81);
		send_event(ACT_TX_READY, 8'h7E);
		send_event(ACT_TX_READY, 8'h00);

		run_mix(120, 30, 20, 30, 20);

		send_idle_pct = 46;
		recv_idle_pct = 30;
		hold_request = 1'b1;
		// Fill the transmit queue past full, then drain it so that its tail wraps.
		run_mix(265, 95, 2, 2, 1);
		run_mix(260, 3, 2, 2, 93);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Fill the receive queue past full so that bytes are dropped and the head wraps.
		run_mix(550, 1, 1, 97, 1);
		run_mix(40, 25, 40, 10, 25);

		in_valid <= 1'b0;
		while (result_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
